/* design/per_peer_congestion_window_defines.svh */
// Assertion macros used by the top-level design file.
`ifndef PER_PEER_CONGESTION_WINDOW_DEFINES_SVH
`define PER_PEER_CONGESTION_WINDOW_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk_i outside reset.
`define PPCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Next-cycle implication: cond at one edge implies prop at the following edge.
`define PPCW_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* design/ppcw_pkg.sv */
package ppcw_pkg;

  localparam int unsigned NUM_PEERS_DEFAULT = 8;

  localparam logic [15:0] START_WINDOW   = 16'd1;
  localparam logic [15:0] INITIAL_PEAK   = 16'd1;
  localparam logic [15:0] WIN_MAX        = 16'hFFFF;
  localparam logic [16:0] CREDIT_MAX     = 17'h1FFFF;

  // Operation codes.
  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  // Growth modes; the fourth code is unused and behaves like idle.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_SLOW  = 2'd1;
  localparam logic [1:0] MODE_AVOID = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_UNKNOWN = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] peer_index;
    logic       peer_known;
    logic [9:0] acked;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [15:0] window;
    logic        window_changed;
  } out_word_t;

  // One peer's table entry.
  typedef struct packed {
    logic [1:0]  growth_mode;
    logic [16:0] ack_credit;
    logic [15:0] peak_window;
    logic [15:0] window_size;
  } entry_t;

endpackage

/* design/ppcw_update.sv */
module ppcw_update (
  input  logic [1:0]      op_i,
  input  logic [9:0]      acked_i,
  input  ppcw_pkg::entry_t cur_i,
  output ppcw_pkg::entry_t nxt_o,
  output logic            changed_o
);

  logic [16:0] win_sum;
  logic [15:0] win_add;
  logic [15:0] win_inc;
  logic [17:0] cred_sum;
  logic [16:0] cred_add;
  logic [15:0] half_peak;
  logic        cred_full;

  always_comb begin
    win_sum   = {1'b0, cur_i.window_size} + 17'(acked_i);
    win_add   = win_sum[16] ? ppcw_pkg::WIN_MAX : win_sum[15:0];
    win_inc   = (cur_i.window_size == ppcw_pkg::WIN_MAX) ? ppcw_pkg::WIN_MAX
                                                         : cur_i.window_size + 16'd1;
    // The credit is at most 131071 and acked at most 1023, so only bit 17 overflows.
    cred_sum  = {1'b0, cur_i.ack_credit} + 18'(acked_i);
    cred_add  = cred_sum[17] ? ppcw_pkg::CREDIT_MAX : cred_sum[16:0];
    half_peak = {1'b0, cur_i.peak_window[15:1]};
    cred_full = cred_add >= {1'b0, cur_i.window_size};
  end

  always_comb begin
    nxt_o     = cur_i;
    changed_o = 1'b0;
    unique case (op_i)
      ppcw_pkg::OP_INIT: begin
        nxt_o.growth_mode = ppcw_pkg::MODE_SLOW;
        nxt_o.window_size = ppcw_pkg::START_WINDOW;
        nxt_o.peak_window = ppcw_pkg::INITIAL_PEAK;
        nxt_o.ack_credit  = '0;
        changed_o         = 1'b1;
      end
      ppcw_pkg::OP_ACK: begin
        unique case (cur_i.growth_mode)
          ppcw_pkg::MODE_SLOW: begin
            nxt_o.window_size = win_add;
            if (win_add > cur_i.peak_window) begin
              nxt_o.peak_window = win_add;
            end
            changed_o = 1'b1;
          end
          ppcw_pkg::MODE_AVOID: begin
            if (cur_i.window_size >= half_peak) begin
              if (cred_full) begin
                nxt_o.ack_credit  = cred_add - 17'(cur_i.window_size);
                nxt_o.window_size = win_inc;
                changed_o         = 1'b1;
              end else begin
                nxt_o.ack_credit = cred_add;
              end
            end else begin
              nxt_o.window_size = win_add;
              changed_o         = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ppcw_pkg::OP_TIMEOUT: begin
        nxt_o.growth_mode = ppcw_pkg::MODE_AVOID;
        nxt_o.window_size = ppcw_pkg::START_WINDOW;
        changed_o         = 1'b1;
      end
      ppcw_pkg::OP_QUERY: begin
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/per_peer_congestion_window.sv */
// Channel  Direction  Handshake                Word
// in       input      in_valid_i / in_ready_o  op, peer_index, peer_known, acked
// out      output     out_valid_o / out_ready_i status, window, window_changed
//
// Each word is read, then updated: the peer entry is read from the table memory in the
// cycle of acceptance, and the update and write-back happen in the update step after it.
// The next word is accepted while a finished result still waits in the output register.
// Reset clears the per-entry valid flags at once, so an entry never written reads as zero.
// A stalled output holds the update step until the output register frees up.
`include "per_peer_congestion_window_defines.svh"

module per_peer_congestion_window #(
  parameter int unsigned NUM_PEERS = ppcw_pkg::NUM_PEERS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ppcw_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ppcw_pkg::out_word_t out_word_o
);

  localparam int unsigned IdxW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
  localparam int unsigned ExtW = (IdxW > 3) ? IdxW : 3;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;

  ppcw_pkg::entry_t   mem_q [NUM_PEERS];
  logic               vld_q [NUM_PEERS];

  ppcw_pkg::in_word_t item_q;
  logic               known_q;
  ppcw_pkg::entry_t   rd_q;
  logic               rd_vld_q;

  logic                out_valid_q;
  ppcw_pkg::out_word_t out_word_q;

  logic [ExtW-1:0] in_ext;
  logic [IdxW-1:0] rd_idx;
  logic            in_known;
  logic [ExtW-1:0] item_ext;
  logic [IdxW-1:0] wr_idx;
  logic            in_acc;
  logic            out_free;
  logic            exec_done;
  logic            wr_en;

  ppcw_pkg::entry_t cur_entry;
  ppcw_pkg::entry_t nxt_entry;
  logic             changed;

  assign in_ext   = ExtW'(in_word_i.peer_index);
  assign rd_idx   = in_ext[IdxW-1:0];
  assign in_known = in_word_i.peer_known &&
                    ({1'b0, in_ext} < (ExtW + 1)'(NUM_PEERS));
  assign item_ext = ExtW'(item_q.peer_index);
  assign wr_idx   = item_ext[IdxW-1:0];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign exec_done  = (state_q == ST_EXEC) && out_free;
  assign wr_en      = exec_done && known_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Table memory: one read port at acceptance, one write port at the update step.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= mem_q[rd_idx];
    end
    if (wr_en) begin
      mem_q[wr_idx] <= nxt_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_PEERS); i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (wr_en) begin
      vld_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q   <= in_word_i;
      known_q  <= in_known;
      rd_vld_q <= in_known ? vld_q[rd_idx] : 1'b0;
    end
  end

  assign cur_entry = rd_vld_q ? rd_q : '0;

  ppcw_update u_update (
    .op_i      (item_q.op),
    .acked_i   (item_q.acked),
    .cur_i     (cur_entry),
    .nxt_o     (nxt_entry),
    .changed_o (changed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_done) begin
      if (known_q) begin
        out_word_q.status         <= ppcw_pkg::STATUS_OK;
        out_word_q.window         <= nxt_entry.window_size;
        out_word_q.window_changed <= changed;
      end else begin
        out_word_q.status         <= ppcw_pkg::STATUS_UNKNOWN;
        out_word_q.window         <= '0;
        out_word_q.window_changed <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `PPCW_ASSERT_NEXT(a_accept_to_exec, in_acc, state_q == ST_EXEC,
                    "accepted word did not enter the update step")
  `PPCW_ASSERT(a_write_in_exec, wr_en |-> (state_q == ST_EXEC && known_q),
               "table written outside the update step of a known peer")
  `PPCW_ASSERT_NEXT(a_stall_holds_exec, state_q == ST_EXEC && out_valid_q && !out_ready_i,
                    state_q == ST_EXEC && out_valid_q,
                    "update step left while the output register was full")
  `PPCW_ASSERT(a_unknown_result,
               (out_valid_q && out_word_q.status == ppcw_pkg::STATUS_UNKNOWN) |->
               (out_word_q.window == '0 && !out_word_q.window_changed),
               "unknown-peer result carries a window or a change flag")

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import ppcw_pkg::*;

  localparam int unsigned NUM_PEERS = NUM_PEERS_DEFAULT;
  localparam int unsigned RANDOM_WORDS = 900;
  localparam int unsigned TAIL_WORDS = 150;
  localparam int unsigned HOLD_AT_RESULT = 300;
  localparam int unsigned HOLD_CYCLES = 150;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  per_peer_congestion_window #(
    .NUM_PEERS(NUM_PEERS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  // Per-peer window state as the block should hold it.
  logic [15:0] cw_window[NUM_PEERS];
  logic [15:0] cw_peak[NUM_PEERS];
  logic [16:0] cw_credit[NUM_PEERS];
  logic [1:0]  cw_mode[NUM_PEERS];

  // Stimulus words, and for directed rows a hand-written result.
  in_word_t  stim_q[$];
  bit        fixed_q[$];
  out_word_t fixed_val_q[$];
  out_word_t window_expect_q[$];

  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned n_errors;
  int unsigned n_directed;
  int unsigned n_op[4];
  int unsigned n_unknown;
  int unsigned n_win_sat;
  int unsigned n_credit_sat;
  int unsigned n_grow_by_credit;
  bit          quiet_tail;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d words accepted, %0d results, %0d still expected",
             n_accepted, n_results, window_expect_q.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  function automatic logic [15:0] sat_window(input logic [15:0] win, input int unsigned add);
    int unsigned sum;
    sum = 32'(win) + add;
    if (sum > WIN_MAX) begin
      n_win_sat++;
      return WIN_MAX;
    end
    return sum[15:0];
  endfunction

  function automatic out_word_t predict_window(input in_word_t w);
    out_word_t   r;
    int unsigned p;
    int unsigned credit;
    r = '0;
    n_op[w.op]++;
    if (!w.peer_known || w.peer_index >= NUM_PEERS) begin
      n_unknown++;
      r.status = STATUS_UNKNOWN;
      return r;
    end
    p = 32'(w.peer_index);
    case (w.op)
      OP_INIT: begin
        cw_mode[p]   = MODE_SLOW;
        cw_window[p] = START_WINDOW;
        cw_peak[p]   = INITIAL_PEAK;
        cw_credit[p] = '0;
        r.window_changed = 1'b1;
      end
      OP_ACK: begin
        if (cw_mode[p] == MODE_SLOW) begin
          cw_window[p] = sat_window(cw_window[p], 32'(w.acked));
          if (cw_window[p] > cw_peak[p]) cw_peak[p] = cw_window[p];
          r.window_changed = 1'b1;
        end else if (cw_mode[p] == MODE_AVOID) begin
          if (cw_window[p] >= (cw_peak[p] >> 1)) begin
            // Near the old peak the window grows by one per window's worth of acks.
            credit = 32'(cw_credit[p]) + 32'(w.acked);
            if (credit > CREDIT_MAX) begin
              credit = CREDIT_MAX;
              n_credit_sat++;
            end
            if (credit >= cw_window[p]) begin
              credit = credit - 32'(cw_window[p]);
              cw_window[p] = sat_window(cw_window[p], 1);
              r.window_changed = 1'b1;
              n_grow_by_credit++;
            end
            cw_credit[p] = credit[16:0];
          end else begin
            cw_window[p] = sat_window(cw_window[p], 32'(w.acked));
            r.window_changed = 1'b1;
          end
        end
      end
      OP_TIMEOUT: begin
        cw_mode[p]   = MODE_AVOID;
        cw_window[p] = START_WINDOW;
        r.window_changed = 1'b1;
      end
      default: ;
    endcase
    r.status = STATUS_OK;
    r.window = cw_window[p];
    return r;
  endfunction

  task automatic add_word(input logic [1:0] op, input int unsigned peer, input bit known,
                          input int unsigned acked, input bit fixed = 1'b0,
                          input logic st = STATUS_OK, input int unsigned win = 0,
                          input bit chg = 1'b0);
    in_word_t  w;
    out_word_t r;
    w.op         = op;
    w.peer_index = peer[2:0];
    w.peer_known = known;
    w.acked      = acked[9:0];
    r.status         = st;
    r.window         = win[15:0];
    r.window_changed = chg;
    stim_q.push_back(w);
    fixed_q.push_back(fixed);
    fixed_val_q.push_back(r);
  endtask

  function automatic int unsigned rand_acked();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(1000, 1023);
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  task automatic add_noise();
    add_word(2'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom_range(0, 3) != 0,
             $urandom_range(0, 1023));
  endtask

  // Init a peer, ramp it in slow start, time it out and let it recover in avoidance.
  task automatic add_climb(input int unsigned peer, input int unsigned n_slow,
                           input int unsigned n_avoid, input bit big_acks);
    add_word(OP_INIT, peer, 1'b1, $urandom_range(0, 1023));
    repeat (n_slow) begin
      add_word(OP_ACK, peer, 1'b1, big_acks ? 1023 : rand_acked());
      if ($urandom_range(0, 15) == 0) add_noise();
    end
    add_word(OP_TIMEOUT, peer, 1'b1, $urandom_range(0, 1023));
    repeat (n_avoid) begin
      add_word(OP_ACK, peer, 1'b1, big_acks ? 1023 : rand_acked());
      if ($urandom_range(0, 15) == 0) add_noise();
    end
    if ($urandom_range(0, 1)) add_word(OP_QUERY, peer, 1'b1, $urandom_range(0, 1023));
  endtask

  task automatic build_stimulus();
    int unsigned peer;
    // Untouched peers read as zero, and acks to an idle peer change nothing.
    add_word(OP_QUERY,   0, 1'b1, 0,    1'b1, STATUS_OK, 0, 1'b0);
    add_word(OP_ACK,     0, 1'b1, 1023, 1'b1, STATUS_OK, 0, 1'b0);
    add_word(OP_TIMEOUT, 1, 1'b0, 0,    1'b1, STATUS_UNKNOWN, 0, 1'b0);
    add_word(OP_INIT,    7, 1'b0, 1023, 1'b1, STATUS_UNKNOWN, 0, 1'b0);
    add_word(OP_INIT,    0, 1'b1, 1023, 1'b1, STATUS_OK, 1, 1'b1);
    add_word(OP_ACK,     0, 1'b1, 0,    1'b1, STATUS_OK, 1, 1'b1);
    add_word(OP_ACK,     0, 1'b1, 1023, 1'b1, STATUS_OK, 1024, 1'b1);
    add_word(OP_QUERY,   0, 1'b1, 1023, 1'b1, STATUS_OK, 1024, 1'b0);
    add_word(OP_TIMEOUT, 0, 1'b1, 0,    1'b1, STATUS_OK, 1, 1'b1);
    // Below half the old peak acks add directly, then the credit takes over.
    add_word(OP_ACK,     0, 1'b1, 600);
    add_word(OP_ACK,     0, 1'b1, 100);
    add_word(OP_ACK,     0, 1'b1, 600);
    add_word(OP_INIT,    7, 1'b1, 0);
    add_word(OP_ACK,     7, 1'b1, 512);
    add_word(OP_ACK,     7, 1'b1, 511);
    // With a peak of one the credit path runs from the first ack.
    add_word(OP_INIT,    3, 1'b1, 0);
    add_word(OP_TIMEOUT, 3, 1'b1, 0);
    add_word(OP_ACK,     3, 1'b1, 0);
    add_word(OP_ACK,     3, 1'b1, 1);
    add_word(OP_ACK,     3, 1'b1, 1023);
    add_word(OP_QUERY,   3, 1'b0, 1023, 1'b1, STATUS_UNKNOWN, 0, 1'b0);
    add_word(OP_ACK,     5, 1'b1, 512);
    add_word(OP_TIMEOUT, 6, 1'b1, 0);
    add_word(OP_ACK,     6, 1'b1, 5);
    add_word(OP_INIT,    0, 1'b1, 0);
    n_directed = stim_q.size();

    // Drive one window into saturation and one credit into saturation first.
    peer = $urandom_range(0, 7);
    add_word(OP_INIT, peer, 1'b1, 0);
    repeat (70) add_word(OP_ACK, peer, 1'b1, 1023);
    add_word(OP_QUERY, peer, 1'b1, 0);
    peer = $urandom_range(0, 7);
    add_word(OP_INIT, peer, 1'b1, 0);
    add_word(OP_TIMEOUT, peer, 1'b1, 0);
    repeat (140) add_word(OP_ACK, peer, 1'b1, $urandom_range(1000, 1023));

    while (stim_q.size() < n_directed + RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5:
          add_climb($urandom_range(0, 7), $urandom_range(0, 20), $urandom_range(1, 40),
                    $urandom_range(0, 15) == 0);
        6, 7:
          repeat ($urandom_range(1, 8)) add_noise();
        default: begin
          // Broken sequences: acks and timeouts with no init, or to an unknown peer.
          peer = $urandom_range(0, 7);
          if ($urandom_range(0, 1)) add_word(OP_TIMEOUT, peer, 1'b1, rand_acked());
          repeat ($urandom_range(1, 6))
            add_word(OP_ACK, peer, $urandom_range(0, 2) != 0, rand_acked());
        end
      endcase
    end
  endtask

  always @(posedge clk_i) begin : watch_ports
    out_word_t pred;
    out_word_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pred = predict_window(in_word_i);
        if (fixed_q[n_accepted]) pred = fixed_val_q[n_accepted];
        window_expect_q.push_back(pred);
        n_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (window_expect_q.size() == 0) begin
          note_error($sformatf({"result word %0d with nothing expected:",
                                " status %0b window %0d changed %0b"},
                               n_results, out_word_o.status, out_word_o.window,
                               out_word_o.window_changed));
        end else begin
          want = window_expect_q.pop_front();
          if (out_word_o.status !== want.status || out_word_o.window !== want.window ||
              out_word_o.window_changed !== want.window_changed) begin
            note_error($sformatf({"result word %0d: expected status %0b window %0d changed %0b,",
                                  " got status %0b window %0d changed %0b"},
                                 n_results, want.status, want.window, want.window_changed,
                                 out_word_o.status, out_word_o.window,
                                 out_word_o.window_changed));
          end
        end
        n_results++;
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back the block up, none in the tail.
  initial begin : drive_ready
    int unsigned stall_pct;
    bit          held;
    stall_pct = 10;
    held      = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      if (!held && n_results >= HOLD_AT_RESULT) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : drive_words
    int unsigned gap_pct;
    for (int p = 0; p < NUM_PEERS; p++) begin
      cw_window[p] = '0;
      cw_peak[p]   = '0;
      cw_credit[p] = '0;
      cw_mode[p]   = MODE_IDLE;
    end
    gap_pct    = 10;
    quiet_tail = 1'b0;
    in_valid_i <= 1'b0;
    in_word_i  <= '0;
    build_stimulus();
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    for (int i = 0; i < stim_q.size(); i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 35;
        endcase
      end
      if (i >= stim_q.size() - TAIL_WORDS) quiet_tail = 1'b1;
      if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_word_i  <= stim_q[i];
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;

    while (n_accepted < stim_q.size() || window_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (window_expect_q.size() != 0)
      note_error($sformatf("%0d expected results never arrived", window_expect_q.size()));

    $display({"Ran %0d words (%0d directed): %0d init, %0d ack, %0d timeout,",
              " %0d query, %0d unknown peer."},
             n_accepted, n_directed, n_op[OP_INIT], n_op[OP_ACK], n_op[OP_TIMEOUT],
             n_op[OP_QUERY], n_unknown);
    $display({"Window saturated %0d times, credit saturated %0d times,",
              " %0d credit growth steps; %0d errors."},
             n_win_sat, n_credit_sat, n_grow_by_credit, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/ppcw_pkg.sv
design/ppcw_update.sv
design/per_peer_congestion_window.sv
tb/tb.sv
